// ===== rtl/core/sigtlv_pkg.sv =====
package sigtlv_pkg;

  localparam int unsigned MaxMsgWords = 16384;
  localparam int unsigned IdxW        = $clog2(MaxMsgWords + 1);
  localparam int unsigned OffsW       = 14;
  localparam int unsigned SkipW       = 14;
  localparam int unsigned HeaderWords = 2;
  localparam int unsigned MinParmLen  = 4;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 16;

  typedef logic [31:0]         word_t;
  typedef logic [15:0]         tag_t;
  typedef logic [15:0]         len_t;
  typedef logic [5:0]          span_t;
  typedef logic [6:0]          slot_t;
  typedef logic [OffsW-1:0]    offs_t;
  typedef logic [IdxW-1:0]     idx_t;
  typedef logic [SkipW-1:0]    skip_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;

  localparam cfg_idx_t CfgCommonBase   = 2'd0;
  localparam cfg_idx_t CfgCommonSpan   = 2'd1;
  localparam cfg_idx_t CfgSpecificBase = 2'd2;
  localparam cfg_idx_t CfgSpecificSpan = 2'd3;

  localparam tag_t  ResetCommonBase   = 16'd1;
  localparam span_t ResetCommonSpan   = 6'd18;
  localparam tag_t  ResetSpecificBase = 16'd512;
  localparam span_t ResetSpecificSpan = 6'd19;

  typedef struct packed {
    slot_t slot_index;
    len_t  parm_length;
    offs_t value_offset;
    word_t first_value;
  } result_t;

endpackage

// ===== rtl/core/sigtlv_if.sv =====
interface sigtlv_msg_if;
  logic                valid;
  logic                ready;
  sigtlv_pkg::word_t   msg_word;
  logic                end_of_msg;

  modport source (output valid, output msg_word, output end_of_msg, input ready);
  modport sink   (input valid, input msg_word, input end_of_msg, output ready);
endinterface

interface sigtlv_res_if;
  logic                valid;
  logic                ready;
  sigtlv_pkg::slot_t   slot_index;
  sigtlv_pkg::len_t    parm_length;
  sigtlv_pkg::offs_t   value_offset;
  sigtlv_pkg::word_t   first_value;

  modport source (output valid, output slot_index, output parm_length,
                  output value_offset, output first_value, input ready);
  modport sink   (input valid, input slot_index, input parm_length,
                  input value_offset, input first_value, output ready);
endinterface

// ===== rtl/core/sigtran_tlv_parameter_indexer.sv =====
// channel  dir  handshake     payload
// msg_i    in   valid/ready   msg_word[31:0], end_of_msg
// res_o    out  valid/ready   slot_index[6:0], parm_length[15:0],
//                             value_offset[13:0], first_value[31:0]
// cfg      in   cfg_we_i      cfg_idx_i[1:0], cfg_data_i[15:0]
//
// one message word per cycle while msg_i.ready is high; each result is
// registered from the word that completes it, in an output register backed
// by a skid register; msg_i.ready drops only while the skid register is occupied
// rst_ni clears the parse state, the output valids and loads the default ranges
module sigtran_tlv_parameter_indexer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  sigtlv_pkg::cfg_idx_t  cfg_idx_i,
  input  sigtlv_pkg::cfg_data_t cfg_data_i,
  sigtlv_msg_if.sink            msg_i,
  sigtlv_res_if.source          res_o
);
  import sigtlv_pkg::*;

  tag_t    common_base_q, specific_base_q;
  span_t   common_span_q, specific_span_q;

  idx_t    word_idx_q, word_idx_d;
  skip_t   skip_q, skip_d;
  logic    halted_q, halted_d;
  logic    pend_valid_q, pend_valid_d;
  slot_t   pend_slot_q, pend_slot_d;
  len_t    pend_len_q, pend_len_d;

  result_t out_q, skid_q, res;
  logic    out_valid_q, skid_valid_q;
  logic    res_valid;

  logic    in_xfer, out_xfer;
  logic    beyond;
  word_t   w;
  tag_t    tag;
  len_t    len;
  logic [16:0] len_rnd;
  tag_t    cdiff, sdiff;
  logic    cmatch, smatch, mapped;
  slot_t   slot;

  assign in_xfer  = msg_i.valid & msg_i.ready;
  assign out_xfer = res_o.valid & res_o.ready;
  assign msg_i.ready = ~skid_valid_q;

  assign w       = msg_i.msg_word;
  assign tag     = w[31:16];
  assign len     = w[15:0];
  assign len_rnd = {1'b0, len} + 17'd3;
  assign beyond  = (word_idx_q >= idx_t'(MaxMsgWords));

  // tag range lookup, common range first
  assign cdiff  = tag - common_base_q;
  assign sdiff  = tag - specific_base_q;
  assign cmatch = (tag >= common_base_q) && (cdiff <= {10'd0, common_span_q});
  assign smatch = (tag >= specific_base_q) && (sdiff <= {10'd0, specific_span_q});
  assign mapped = cmatch | smatch;
  assign slot   = cmatch ? cdiff[6:0]
                         : ({1'b0, common_span_q} + 7'd1 + sdiff[6:0]);

  always_comb begin
    word_idx_d   = word_idx_q;
    skip_d       = skip_q;
    halted_d     = halted_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    pend_len_d   = pend_len_q;
    res_valid    = 1'b0;
    res          = '0;

    if (pend_valid_q) begin
      res_valid          = 1'b1;
      res.slot_index     = pend_slot_q;
      res.parm_length    = pend_len_q;
      res.value_offset   = word_idx_q[OffsW-1:0];
      res.first_value    = beyond ? '0 : w;
      pend_valid_d       = 1'b0;
    end

    if (!beyond && !halted_q) begin
      if (skip_q != '0) begin
        skip_d = skip_q - skip_t'(1);
      end else if (len < len_t'(MinParmLen)) begin
        halted_d = 1'b1;
      end else begin
        skip_d = len_rnd[15:2] - skip_t'(1);
        if (mapped) begin
          if (msg_i.end_of_msg) begin
            if (!pend_valid_q) begin
              res_valid        = 1'b1;
              res.slot_index   = slot;
              res.parm_length  = len;
              res.value_offset = word_idx_q[OffsW-1:0] + offs_t'(1);
              res.first_value  = '0;
            end
          end else begin
            pend_valid_d = 1'b1;
            pend_slot_d  = slot;
            pend_len_d   = len;
          end
        end
      end
    end

    if (msg_i.end_of_msg) begin
      word_idx_d   = '0;
      skip_d       = skip_t'(HeaderWords);
      halted_d     = 1'b0;
      pend_valid_d = 1'b0;
      pend_slot_d  = '0;
      pend_len_d   = '0;
    end else if (!beyond) begin
      word_idx_d = word_idx_q + idx_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      common_base_q   <= ResetCommonBase;
      common_span_q   <= ResetCommonSpan;
      specific_base_q <= ResetSpecificBase;
      specific_span_q <= ResetSpecificSpan;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCommonBase:   common_base_q   <= cfg_data_i;
        CfgCommonSpan:   common_span_q   <= cfg_data_i[5:0];
        CfgSpecificBase: specific_base_q <= cfg_data_i;
        CfgSpecificSpan: specific_span_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_idx_q   <= '0;
      skip_q       <= skip_t'(HeaderWords);
      halted_q     <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
      pend_len_q   <= '0;
    end else if (in_xfer) begin
      word_idx_q   <= word_idx_d;
      skip_q       <= skip_d;
      halted_q     <= halted_d;
      pend_valid_q <= pend_valid_d;
      pend_slot_q  <= pend_slot_d;
      pend_len_q   <= pend_len_d;
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_xfer) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_xfer && res_valid) begin
      if (out_valid_q && !out_xfer) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_xfer) begin
        out_q <= skid_q;
      end
    end else if (in_xfer && res_valid) begin
      if (out_valid_q && !out_xfer) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.slot_index   = out_q.slot_index;
  assign res_o.parm_length  = out_q.parm_length;
  assign res_o.value_offset = out_q.value_offset;
  assign res_o.first_value  = out_q.first_value;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import sigtlv_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomWords  = 1650;
  localparam int unsigned NumPhases    = 6;
  localparam int unsigned NumDirRows   = 27;
  localparam int unsigned IdlePct      = 25;
  localparam int unsigned SettleCycles = 8;

  typedef struct packed {
    word_t   w;
    logic    eom;
    logic    chk;
    result_t exp;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_idx_t  cfg_idx_i;
  cfg_data_t cfg_data_i;

  sigtlv_msg_if msg_if ();
  sigtlv_res_if res_if ();

  sigtran_tlv_parameter_indexer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .msg_i      (msg_if),
    .res_o      (res_if)
  );

  // range registers as the block should hold them
  tag_t  common_base;
  span_t common_span;
  tag_t  spec_base;
  span_t spec_span;

  // message walk state
  int unsigned word_pos;
  int unsigned words_left;
  bit          halted;
  bit          pend;
  slot_t       pend_slot;
  len_t        pend_len;

  result_t     param_q [$];
  dir_row_t    dir_rows [NumDirRows];

  bit          no_idle;
  int unsigned cycles;
  int unsigned words_sent;
  int unsigned msgs_sent;
  int unsigned params_checked;
  int unsigned cfg_settings;
  int unsigned n_bad;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d reports outstanding", cycles, param_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_msg_state();
    word_pos   = 0;
    words_left = HeaderWords;
    halted     = 1'b0;
    pend       = 1'b0;
    pend_slot  = '0;
    pend_len   = '0;
  endfunction

  function automatic bit tag_to_slot(input tag_t tag, output slot_t slot);
    int unsigned d;
    slot = '0;
    if (tag >= common_base) begin
      d = int'(tag) - int'(common_base);
      if (d <= common_span) begin
        slot = slot_t'(d);
        return 1'b1;
      end
    end
    if (tag >= spec_base) begin
      d = int'(tag) - int'(spec_base);
      if (d <= spec_span) begin
        slot = slot_t'(int'(common_span) + 1 + d);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void parse_word(input word_t w, input logic last,
                                     output bit got, output result_t r);
    int unsigned idx;
    bit          beyond;
    len_t        len;
    slot_t       slot;
    idx    = word_pos;
    beyond = idx >= MaxMsgWords;
    got    = 1'b0;
    r      = '0;
    if (pend) begin
      r.slot_index   = pend_slot;
      r.parm_length  = pend_len;
      r.value_offset = offs_t'(idx);
      r.first_value  = beyond ? '0 : w;
      pend = 1'b0;
      got  = 1'b1;
    end
    if (!beyond && !halted) begin
      if (words_left > 0) begin
        words_left--;
      end else begin
        len = w[15:0];
        if (len < MinParmLen) begin
          halted = 1'b1;
        end else begin
          words_left = (int'(len) + 3) / 4 - 1;
          if (tag_to_slot(w[31:16], slot)) begin
            if (last) begin
              if (!got) begin
                r.slot_index   = slot;
                r.parm_length  = len;
                r.value_offset = offs_t'(idx + 1);
                r.first_value  = '0;
                got = 1'b1;
              end
            end else begin
              pend      = 1'b1;
              pend_slot = slot;
              pend_len  = len;
            end
          end
        end
      end
    end
    if (last) clear_msg_state();
    else if (!beyond) word_pos = idx + 1;
  endfunction

  task automatic send_word(input word_t w, input logic last, input bit typed,
                           input result_t typed_res);
    bit      got;
    result_t r;
    if (!no_idle) begin
      while ($urandom_range(99) < IdlePct) begin
        msg_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    msg_if.valid      <= 1'b1;
    msg_if.msg_word   <= w;
    msg_if.end_of_msg <= last;
    @(posedge clk_i);
    while (!msg_if.ready) @(posedge clk_i);
    parse_word(w, last, got, r);
    if (typed) begin
      got = 1'b1;
      r   = typed_res;
    end
    if (got) param_q.push_back(r);
    words_sent++;
    if (last) msgs_sent++;
  endtask

  task automatic wait_drain();
    msg_if.valid <= 1'b0;
    while (param_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CfgCommonBase:   common_base = data;
      CfgCommonSpan:   common_span = data[5:0];
      CfgSpecificBase: spec_base   = data;
      CfgSpecificSpan: spec_span   = data[5:0];
      default: ;
    endcase
  endtask

  task automatic set_ranges(input cfg_data_t cb, input cfg_data_t cs,
                            input cfg_data_t sb, input cfg_data_t ss);
    write_reg(CfgCommonBase, cb);
    write_reg(CfgCommonSpan, cs);
    write_reg(CfgSpecificBase, sb);
    write_reg(CfgSpecificSpan, ss);
    cfg_we_i <= 1'b0;
    cfg_settings++;
  endtask

  // mostly well-formed messages; some truncated or with odd lengths
  task automatic send_random_msg();
    word_t words [$];
    int    n_parm;
    int    kind;
    int    nw;
    bit    stop;
    tag_t  tag;
    len_t  len;
    words.push_back($urandom());
    words.push_back($urandom());
    n_parm = $urandom_range(6);
    stop   = 1'b0;
    for (int p = 0; p < n_parm && !stop; p++) begin
      kind = $urandom_range(99);
      if (kind < 35) tag = common_base + tag_t'($urandom_range(int'(common_span) + 1));
      else if (kind < 65) tag = spec_base + tag_t'($urandom_range(int'(spec_span) + 1));
      else if (kind < 75) tag = (kind < 70) ? common_base - 1 : spec_base - 1;
      else tag = tag_t'($urandom());
      kind = $urandom_range(99);
      if (kind < 6) len = len_t'($urandom_range(3));
      else if (kind < 12) len = len_t'($urandom());
      else len = len_t'($urandom_range(24, 4));
      words.push_back({tag, len});
      if (len < MinParmLen) begin
        nw   = $urandom_range(2);
        stop = 1'b1;
      end else begin
        nw = (int'(len) + 3) / 4 - 1;
        if (nw > 6) begin
          nw   = $urandom_range(4, 1);
          stop = 1'b1;
        end
      end
      for (int i = 0; i < nw; i++) words.push_back($urandom());
    end
    if ($urandom_range(99) < 15) words = words[0:$urandom_range(words.size() - 1)];
    foreach (words[i]) send_word(words[i], i == words.size() - 1, 1'b0, '0);
  endtask

  // a mapped header at the last parsed index; its value word lies past the end
  task automatic send_overlong_msg();
    send_word($urandom(), 1'b0, 1'b0, '0);
    send_word($urandom(), 1'b0, 1'b0, '0);
    send_word({16'hFFFF, 16'd65524}, 1'b0, 1'b0, '0);
    for (int i = 3; i < MaxMsgWords - 1; i++) send_word($urandom(), 1'b0, 1'b0, '0);
    send_word({16'h0001, 16'h0004}, 1'b0, 1'b0, '0);
    for (int i = 0; i < 3; i++) send_word($urandom(), i == 2, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (param_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected report: slot %0d len %0d offs %0d value %h",
                   res_if.slot_index, res_if.parm_length, res_if.value_offset,
                   res_if.first_value);
      end else begin
        e = param_q.pop_front();
        params_checked++;
        if (res_if.slot_index !== e.slot_index || res_if.parm_length !== e.parm_length ||
            res_if.value_offset !== e.value_offset ||
            res_if.first_value !== e.first_value) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp slot %0d len %0d offs %0d value %h, got slot %0d len %0d offs %0d value %h",
                     e.slot_index, e.parm_length, e.value_offset, e.first_value,
                     res_if.slot_index, res_if.parm_length, res_if.value_offset,
                     res_if.first_value);
        end
      end
    end
    res_if.ready <= no_idle || ($urandom_range(99) >= IdlePct);
  end

  initial begin
    int unsigned phase_words;
    cfg_data_t   base;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = CfgCommonBase;
    cfg_data_i        = '0;
    msg_if.valid      = 1'b0;
    msg_if.msg_word   = '0;
    msg_if.end_of_msg = 1'b0;
    res_if.ready      = 1'b0;
    no_idle           = 1'b0;
    cycles            = 0;
    words_sent        = 0;
    msgs_sent         = 0;
    params_checked    = 0;
    cfg_settings      = 1;
    n_bad             = 0;
    common_base       = ResetCommonBase;
    common_span       = ResetCommonSpan;
    spec_base         = ResetSpecificBase;
    spec_span         = ResetSpecificSpan;
    clear_msg_state();

    dir_rows = '{
      {32'h01000000, 1'b0, 1'b0, 69'd0},
      {32'h00000010, 1'b0, 1'b0, 69'd0},
      {32'h00010008, 1'b0, 1'b0, 69'd0},
      {32'hFFFFFFFF, 1'b0, 1'b1, {7'd0, 16'd8, 14'd3, 32'hFFFFFFFF}},
      {32'h00130004, 1'b0, 1'b0, 69'd0},
      {32'h02130004, 1'b0, 1'b1, {7'd18, 16'd4, 14'd5, 32'h02130004}},
      {32'h00000000, 1'b0, 1'b1, {7'd38, 16'd4, 14'd6, 32'h00000000}},
      {32'h00010008, 1'b0, 1'b0, 69'd0},
      {32'hFFFFFFFF, 1'b1, 1'b0, 69'd0},
      {32'hFFFFFFFF, 1'b0, 1'b0, 69'd0},
      {32'h00000000, 1'b0, 1'b0, 69'd0},
      {32'h0000000C, 1'b0, 1'b0, 69'd0},
      {32'hAAAAAAAA, 1'b0, 1'b0, 69'd0},
      {32'h55555555, 1'b0, 1'b0, 69'd0},
      {32'h00140005, 1'b0, 1'b0, 69'd0},
      {32'h12345678, 1'b0, 1'b0, 69'd0},
      {32'h01FF0004, 1'b0, 1'b0, 69'd0},
      {32'h0200FFFF, 1'b1, 1'b1, {7'd19, 16'hFFFF, 14'd9, 32'h00000000}},
      {32'h00000000, 1'b0, 1'b0, 69'd0},
      {32'h00000000, 1'b0, 1'b0, 69'd0},
      {32'h00020004, 1'b0, 1'b0, 69'd0},
      {32'h00030004, 1'b1, 1'b1, {7'd1, 16'd4, 14'd3, 32'h00030004}},
      {32'h00000000, 1'b0, 1'b0, 69'd0},
      {32'h00000000, 1'b0, 1'b0, 69'd0},
      {32'h00050003, 1'b0, 1'b0, 69'd0},
      {32'h00050004, 1'b1, 1'b0, 69'd0},
      {32'h12345678, 1'b1, 1'b0, 69'd0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].w, dir_rows[i].eom, dir_rows[i].chk, dir_rows[i].exp);
    send_overlong_msg();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        wait_drain();
        case (ph)
          1: set_ranges(16'h0000, 16'd63, 16'hFFC0, 16'd63);
          2: set_ranges(16'hFFFF, 16'd0, 16'h0000, 16'd0);
          3, 4: begin
            base = cfg_data_t'($urandom());
            set_ranges(base, cfg_data_t'($urandom_range(63)),
                       base + cfg_data_t'($urandom_range(10)), cfg_data_t'($urandom_range(63)));
          end
          default: set_ranges(cfg_data_t'($urandom()), cfg_data_t'($urandom()),
                              cfg_data_t'($urandom()), cfg_data_t'($urandom()));
        endcase
      end
      no_idle     = (ph == 1);
      phase_words = words_sent;
      while (words_sent - phase_words < RandomWords / NumPhases) send_random_msg();
    end

    wait_drain();
    if (param_q.size() != 0) n_bad += param_q.size();
    $display("%0d message words in %0d messages, %0d range settings, one overlong message",
             words_sent, msgs_sent, cfg_settings);
    $display("%0d parameter reports checked, %0d failures", params_checked, n_bad);
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
